// File: rtl/integer_to_ascii_radix_defines.svh
// Assertion macros shared by the integer-to-text converter.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

`ifndef ASSERT_OFF
`define ITAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ITAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITAR_ASSERT(label, prop, msg)
`define ITAR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/itar_pkg.sv
// Types, constants and helper functions of the integer-to-text converter.
package itar_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned CHUNK_BITS = 8;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PC_W = 4;

  localparam logic [APB_ADDR_W-1:0] REG_RADIX = 2'd0;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [PC_W-1:0] STEP_DIV = 4'd1;
  localparam logic [PC_W-1:0] STEP_PUSH = 4'd2;
  localparam logic [PC_W-1:0] STEP_SIGN_CHK = 4'd3;
  localparam logic [PC_W-1:0] STEP_SIGN = 4'd4;
  localparam logic [PC_W-1:0] STEP_POP = 4'd5;
  localparam logic [PC_W-1:0] STEP_EMIT = 4'd6;
  localparam logic [PC_W-1:0] STEP_NEXT = 4'd7;
  localparam logic [PC_W-1:0] STEP_DONE = 4'd8;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_CHUNK_MORE,
    COND_DIGIT_MORE,
    COND_NOT_NEG,
    COND_OUT_BUSY,
    COND_DIGITS_LEFT
  } itar_cond_e;

  typedef struct packed {
    logic            in_ready;
    logic            div;
    logic            push;
    logic            emit_sign;
    logic            pop;
    logic            emit_digit;
    itar_cond_e      cond;
    logic [PC_W-1:0] target;
  } itar_ctrl_t;

  typedef struct packed {
    logic accept;
    logic chunk_more;
    logic digit_more;
    logic neg;
    logic out_busy;
    logic digits_left;
  } itar_stat_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_MAX) begin
      c = CHAR_LOWER_A + (CHAR_W'(d) - (CHAR_W'(DIGIT_MAX) + 7'd1));
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// File: rtl/integer_to_ascii_radix.sv
// Top level of the integer-to-text converter with its radix register and APB port.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_ready_o   value_i
//   out      source     out_valid_o / out_ready_i char_code_o, last_o
//   cfg      APB slave  psel, penable, pready     paddr, pwdata, prdata
//
// Each digit comes from the divider, which retires eight quotient bits per cycle, and is
// pushed on the digit stack; each character is then popped from the stack and emitted,
// led by a minus sign for a negative value. A new value is accepted only once the
// sequencer is back in its idle step after the last character.
// Reset is asynchronous and sets the radix to ten; no clearing pass is needed.
// A stalled output holds its character while the sequencer waits before the next one.
`include "integer_to_ascii_radix_defines.svh"

module integer_to_ascii_radix #(
  parameter int unsigned VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]     value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [itar_pkg::CHAR_W-1:0]       char_code_o,
  output logic                              last_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [itar_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [itar_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [itar_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import itar_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] base;
  itar_ctrl_t         ctrl;
  itar_stat_t         stat;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_RADIX) ? APB_DATA_W'(radix_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_RADIX)) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  assign base = clamp_radix(radix_q);

  itar_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  itar_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .value_i     (value_i),
    .base_i      (base),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  assign in_ready_o = ctrl.in_ready;

  `ITAR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "Accepted a transaction but stayed ready.")
  `ITAR_ASSERT(a_stack_empty_when_ready, !in_ready_o || !stat.digits_left, "Ready while digits remain on the stack.")
  `ITAR_ASSERT(a_legal_char, !out_valid_o || (char_code_o == CHAR_MINUS) || ((char_code_o >= CHAR_ZERO) && (char_code_o <= CHAR_ZERO + 7'd9)) || ((char_code_o >= CHAR_LOWER_A) && (char_code_o <= CHAR_LOWER_A + 7'd25)), "Output character outside the digit set.")

endmodule

// File: rtl/itar_sequencer.sv
// Microcode table and step counter that drive the conversion datapath.
module itar_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itar_pkg::itar_stat_t stat_i,
  output itar_pkg::itar_ctrl_t ctrl_o
);
  import itar_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic            jump;

  function automatic itar_ctrl_t uword(logic rdy, logic dv, logic psh, logic sgn, logic pp,
                                       logic emt, itar_cond_e c, logic [PC_W-1:0] t);
    itar_ctrl_t w;
    w.in_ready   = rdy;
    w.div        = dv;
    w.push       = psh;
    w.emit_sign  = sgn;
    w.pop        = pp;
    w.emit_digit = emt;
    w.cond       = c;
    w.target     = t;
    return w;
  endfunction

  always_comb begin
    unique case (pc_q)
      STEP_IDLE:     ctrl_o = uword(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NO_ACCEPT, STEP_IDLE);
      STEP_DIV:      ctrl_o = uword(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, COND_CHUNK_MORE, STEP_DIV);
      STEP_PUSH:     ctrl_o = uword(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_DIGIT_MORE, STEP_DIV);
      STEP_SIGN_CHK: ctrl_o = uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NOT_NEG, STEP_POP);
      STEP_SIGN:     ctrl_o = uword(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_OUT_BUSY, STEP_SIGN);
      STEP_POP:      ctrl_o = uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, COND_NEVER, STEP_IDLE);
      STEP_EMIT:     ctrl_o = uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, COND_OUT_BUSY, STEP_EMIT);
      STEP_NEXT:     ctrl_o = uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, COND_DIGITS_LEFT,
                                    STEP_EMIT);
      STEP_DONE:     ctrl_o = uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_IDLE);
      default:       ctrl_o = uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_IDLE);
    endcase
  end

  always_comb begin
    unique case (ctrl_o.cond)
      COND_NEVER:       jump = 1'b0;
      COND_ALWAYS:      jump = 1'b1;
      COND_NO_ACCEPT:   jump = !stat_i.accept;
      COND_CHUNK_MORE:  jump = stat_i.chunk_more;
      COND_DIGIT_MORE:  jump = stat_i.digit_more;
      COND_NOT_NEG:     jump = !stat_i.neg;
      COND_OUT_BUSY:    jump = stat_i.out_busy;
      COND_DIGITS_LEFT: jump = stat_i.digits_left;
      default:          jump = 1'b1;
    endcase
  end

  assign pc_d = jump ? ctrl_o.target : pc_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: rtl/itar_datapath.sv
// Divider, digit stack and output register of the integer-to-text converter.
module itar_datapath #(
  parameter int unsigned VALUE_WIDTH = itar_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  itar_pkg::itar_ctrl_t            ctrl_i,
  output itar_pkg::itar_stat_t            stat_o,
  input  logic                            in_valid_i,
  input  logic signed [VALUE_WIDTH-1:0]   value_i,
  input  logic [itar_pkg::RADIX_W-1:0]    base_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [itar_pkg::CHAR_W-1:0]     char_code_o,
  output logic                            last_o
);
  import itar_pkg::*;

  localparam int unsigned CHUNKS = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned MAG_W = CHUNKS * CHUNK_BITS;
  localparam int unsigned CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned ND_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);

  logic [MAG_W-1:0]   mag_q, div_mag, val_abs;
  logic [RADIX_W-1:0] rem_q, div_rem;
  logic [CNT_W-1:0]   chunk_q;
  logic [ND_W-1:0]    nd_q;
  logic               neg_q;
  logic [RADIX_W-1:0] rd_q;
  logic [RADIX_W-1:0] stack_q [VALUE_WIDTH];
  logic [ADDR_W-1:0]  rd_addr;
  logic               accept, pop_en, out_busy, emit;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;
  logic [RADIX_W:0]   trial;

  assign accept = ctrl_i.in_ready & in_valid_i;
  assign val_abs = MAG_W'(value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i);

  always_comb begin
    div_rem = rem_q;
    div_mag = mag_q;
    trial = '0;
    for (int k = 0; k < CHUNK_BITS; k++) begin
      trial = {div_rem, div_mag[MAG_W-1]};
      div_mag = {div_mag[MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, base_i}) begin
        div_rem = RADIX_W'(trial - {1'b0, base_i});
        div_mag[0] = 1'b1;
      end else begin
        div_rem = trial[RADIX_W-1:0];
      end
    end
  end

  assign pop_en = ctrl_i.pop && (nd_q != '0);
  assign rd_addr = ADDR_W'(nd_q - 1'b1);
  assign out_busy = out_valid_q & ~out_ready_i;
  assign emit = (ctrl_i.emit_sign | ctrl_i.emit_digit) & ~out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      nd_q    <= '0;
      neg_q   <= 1'b0;
    end else if (accept) begin
      chunk_q <= '0;
      nd_q    <= '0;
      neg_q   <= value_i[VALUE_WIDTH-1];
    end else if (ctrl_i.div) begin
      chunk_q <= chunk_q + 1'b1;
    end else if (ctrl_i.push) begin
      chunk_q <= '0;
      nd_q    <= nd_q + 1'b1;
    end else if (pop_en) begin
      nd_q <= nd_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q <= val_abs;
      rem_q <= '0;
    end else if (ctrl_i.div) begin
      mag_q <= div_mag;
      rem_q <= div_rem;
    end else if (ctrl_i.push) begin
      rem_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      stack_q[nd_q[ADDR_W-1:0]] <= rem_q;
    end
    if (pop_en) begin
      rd_q <= stack_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= ctrl_i.emit_sign ? CHAR_MINUS : digit_to_char(rd_q);
      last_q <= ctrl_i.emit_digit & (nd_q == '0);
    end
  end

  assign stat_o.accept      = accept;
  assign stat_o.chunk_more  = (chunk_q != CNT_W'(CHUNKS - 1));
  assign stat_o.digit_more  = (mag_q != '0) && (nd_q < ND_W'(VALUE_WIDTH - 1));
  assign stat_o.neg         = neg_q;
  assign stat_o.out_busy    = out_busy;
  assign stat_o.digits_left = (nd_q != '0);

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

// File: test/integer_to_ascii_radix_checker.sv
// Checker for the integer-to-text converter: predicts every character and compares it.
`timescale 1ns / 1ps

module integer_to_ascii_radix_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [itar_pkg::VALUE_WIDTH_DEF-1:0] value_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [itar_pkg::CHAR_W-1:0]         char_code_i,
  input  logic                                last_i,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [itar_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [itar_pkg::APB_DATA_W-1:0]     pwdata,
  input  logic                                pready,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  values_o,
  output int                                  chars_o
);
  import itar_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t         expected_text[$];
  text_char_t         want;
  logic [RADIX_W-1:0] radix_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    values_o     = 0;
    chars_o      = 0;
    radix_q      = RADIX_RESET;
  end

  function automatic void predict_text(input logic [VW-1:0] raw);
    logic [VW-1:0]     mag;
    logic [VW-1:0]     base;
    logic [VW-1:0]     digit;
    logic [CHAR_W-1:0] digit_stack[VW];
    int                n;
    text_char_t        c;
    n = 0;
    base = VW'(radix_q);
    if (base < 2) begin
      base = 2;
    end else if (base > 36) begin
      base = 36;
    end
    mag = raw[VW-1] ? (~raw + 1'b1) : raw;
    do begin
      digit = mag % base;
      mag = mag / base;
      digit_stack[n] = (digit > 9) ? CHAR_LOWER_A + CHAR_W'(digit - 10)
                                   : CHAR_ZERO + CHAR_W'(digit);
      n++;
    end while (mag != 0 && n < VW);
    if (raw[VW-1]) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.code = digit_stack[i];
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      expected_text.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_RADIX) begin
        radix_q = pwdata[RADIX_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        chars_o++;
        if (expected_text.size() == 0) begin
          fail_count_o++;
          $display("%0t: character %h last %b arrived with nothing expected",
                   $time, char_code_i, last_i);
        end else begin
          want = expected_text.pop_front();
          if (char_code_i !== want.code) begin
            fail_count_o++;
            $display("%0t: char_code mismatch, expected %h actual %h",
                     $time, want.code, char_code_i);
          end
          if (last_i !== want.last) begin
            fail_count_o++;
            $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        values_o++;
        predict_text(value_i);
      end
      pending_o = expected_text.size();
    end
  end

endmodule

// File: test/testbench.sv
// Top of the testbench for the integer-to-text converter: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import itar_pkg::*;

  localparam int VW             = VALUE_WIDTH_DEF;
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 80;
  localparam int HOLD_CYCLES    = 600;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 35;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [VW-1:0]         value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CHAR_W-1:0]     char_code_o;
  logic                  last_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          fail_count;
  int          pending;
  int          values_done;
  int          chars_done;
  int unsigned idle_pct = 8;
  bit          hold_req = 1'b0;
  int unsigned radix_now = RADIX_RESET;
  int          radix_settings = 1;
  int          quiet_cycles = 0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  integer_to_ascii_radix #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_code_o(char_code_o),
    .last_o     (last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  integer_to_ascii_radix_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_i (char_code_o),
    .last_i      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .values_o    (values_done),
    .chars_o     (chars_done)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic send_value(input logic [VW-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_radix(input int unsigned r);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_RADIX;
    pwdata  <= ($urandom() & ~32'h3f) | (r & 32'h3f);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    radix_now = r & 32'h3f;
    radix_settings++;
  endtask

  function automatic logic [VW-1:0] pick_value(input int unsigned r);
    int unsigned   base;
    int unsigned   sel;
    int unsigned   k;
    logic [VW-1:0] pw;
    logic [VW-1:0] v;
    base = (r < 2) ? 2 : (r > 36) ? 36 : r;
    sel = $urandom_range(99);
    if (sel < 50) begin
      v = $urandom();
    end else if (sel < 70) begin
      v = $urandom_range(0, 2 * base);
    end else if (sel < 85) begin
      pw = 1;
      k = $urandom_range(1, VW - 1);
      repeat (k) begin
        if (pw <= 32'h7fffffff / base) pw = pw * base;
      end
      v = pw - $urandom_range(0, 1);
    end else if ($urandom_range(1) == 1) begin
      v = 32'h80000000 + $urandom_range(0, 3);
    end else begin
      v = 32'h7fffffff - $urandom_range(0, 3);
    end
    if (sel >= 50 && sel < 85 && $urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  initial begin
    int unsigned r;
    int unsigned fixed_radix[RANDOM_PHASES];
    fixed_radix = '{16, 8, 5, 10, 2, 37, 36, 1, 63, 10};
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part in the reset radix of ten.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffffffff);
    send_value(32'd9);
    send_value(-32'd10);
    send_value(32'h7fffffff);
    send_value(32'h80000000);
    send_value(32'd1234567890);
    drain();

    write_radix(2);
    send_value(32'd0);
    send_value(32'h80000000);
    send_value(32'h7fffffff);
    send_value(32'h55555555);
    send_value(32'hffffffff);
    drain();

    write_radix(36);
    send_value(32'd35);
    send_value(32'd36);
    send_value(-32'd35);
    send_value(32'h80000000);
    send_value(32'd1295);
    drain();

    write_radix(0);
    send_value(32'd6);
    drain();
    write_radix(1);
    send_value(-32'd6);
    drain();
    write_radix(37);
    send_value(32'd35);
    drain();
    write_radix(63);
    send_value(32'd1296);
    drain();

    // Random part, one radix setting per phase.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      r = (ph inside {2, 7, 9}) ? $urandom_range(2, 36) : fixed_radix[ph];
      write_radix(r);
      idle_pct = (ph == 3) ? 0 : 8;
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 7 && i == PHASE_ITEMS / 2) drain();
        send_value(pick_value(radix_now));
      end
      drain();
    end
    idle_pct = 8;

    $display("Converted %0d values into %0d characters over %0d radix settings,",
             values_done, chars_done, radix_settings);
    $display("with zero, both extremes, clamped radix codes and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
